[sv/dominant_color_chroma_key_defines.svh]
// assertion macros for the dominant color chroma key block
`ifndef DOMINANT_COLOR_CHROMA_KEY_DEFINES_SVH
`define DOMINANT_COLOR_CHROMA_KEY_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define DCCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen outside reset
`define DCCK_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[sv/dcck_pkg.sv]
// shared constants, types and helper functions for the chroma key block
`timescale 1ns / 1ps
`default_nettype none
package dcck_pkg;

  localparam int unsigned Buckets    = 4;
  localparam int unsigned CountWidth = 22;
  localparam int unsigned BucketSize = 256 / Buckets;
  localparam int unsigned BinTotal   = Buckets * Buckets * Buckets;
  localparam int unsigned BucketW    = $clog2(Buckets);
  localparam int unsigned BinAw      = $clog2(BinTotal);

  typedef logic [BucketW-1:0]    bucket_t;
  typedef logic [BinAw-1:0]      bin_addr_t;
  typedef logic [CountWidth-1:0] count_t;

  localparam count_t     CountMax = {CountWidth{1'b1}};
  localparam logic [7:0] KeyReset = 8'(BucketSize / 2);

  typedef struct packed {
    logic      en;
    bin_addr_t addr;
    count_t    data;
  } hist_wr_t;

  function automatic bucket_t bucket_of(logic [7:0] v);
    logic [BucketW+7:0] prod;
    prod = {{BucketW{1'b0}}, v} * (BucketW + 8)'(Buckets);
    return prod[BucketW+7:8];
  endfunction

  function automatic bin_addr_t bin_index(bucket_t r, bucket_t g, bucket_t b);
    bin_addr_t idx;
    idx = (BinAw'(r) * BinAw'(Buckets) + BinAw'(g)) * BinAw'(Buckets) + BinAw'(b);
    return idx;
  endfunction

  function automatic logic [7:0] key_of(bucket_t k);
    logic [15:0] t;
    t = 16'(k) * 16'(BucketSize) + 16'(BucketSize / 2);
    return t[7:0];
  endfunction

  function automatic logic near_key(logic [7:0] p, logic [7:0] k, logic [7:0] tol);
    logic [7:0] d;
    d = (p >= k) ? (p - k) : (k - p);
    return d <= tol;
  endfunction

endpackage
`default_nettype wire

[sv/dominant_color_chroma_key.sv]
// top level of the dominant color chroma key block
// throughput: one count or replace request per cycle while in_ready_o is high
// a replace result is registered and shows in the cycle after its acceptance
// a frame-end count request stalls input through its own bin write (StWait),
//   a memory read of each of the 64 bins (StScan) and the final compare (StDrain)
// reset: bin valid bits cleared at once (no clearing pass), key 32/32/32, tolerance 64
`timescale 1ns / 1ps
`default_nettype none
module dominant_color_chroma_key import dcck_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  // pixel request channel
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire         operation_i,
  input  wire  [7:0]  pixel_red_i,
  input  wire  [7:0]  pixel_green_i,
  input  wire  [7:0]  pixel_blue_i,
  input  wire  [7:0]  bg_red_i,
  input  wire  [7:0]  bg_green_i,
  input  wire  [7:0]  bg_blue_i,
  input  wire         frame_end_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        replaced_o,
  output logic [7:0]  key_red_now_o,
  output logic [7:0]  key_green_now_o,
  output logic [7:0]  key_blue_now_o,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // sequencer states
  localparam logic [1:0] StRun   = 2'd0;  // taking pixel requests
  localparam logic [1:0] StWait  = 2'd1;  // frame-end bin being written
  localparam logic [1:0] StScan  = 2'd2;  // reading and clearing bins
  localparam logic [1:0] StDrain = 2'd3;  // last bin compare

  localparam logic [2:0]  AddrTolerance = 3'd0;
  localparam logic        OpCount       = 1'b0;
  localparam logic        OpReplace     = 1'b1;
  localparam bucket_t     BucketLast    = BucketW'(Buckets - 1);

  logic [1:0] state_q, state_d;

  // configuration
  logic [7:0] tol_q;
  logic       cfg_wr;

  // key color
  logic [7:0] key_r_q, key_g_q, key_b_q;
  logic [7:0] key_r_d, key_g_d, key_b_d;

  // count pipeline stage: bin read issued last cycle, write this cycle
  logic      s1_valid_q;
  bin_addr_t s1_addr_q;

  // forwarding of the count write done at the edge of the last read
  logic      fwd_en_q;
  bin_addr_t fwd_addr_q;
  count_t    fwd_data_q;

  // scan counters walk the bins in index order
  bucket_t   scan_r_q, scan_g_q, scan_b_q;
  bucket_t   scan_r_d, scan_g_d, scan_b_d;
  logic      scan_last;

  // compare stage of the scan
  logic      cmp_valid_q;
  bucket_t   cmp_r_q, cmp_g_q, cmp_b_q;
  count_t    top_q, top_d;
  bucket_t   best_r_q, best_g_q, best_b_q;
  bucket_t   best_r_d, best_g_d, best_b_d;
  logic      cmp_take;
  logic      cmp_last;

  // output register
  logic       out_valid_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       replaced_q;
  logic [7:0] okey_r_q, okey_g_q, okey_b_q;

  logic       in_accept;
  logic       hit;
  bin_addr_t  pix_addr;
  bin_addr_t  scan_addr;
  bin_addr_t  rd_addr;
  count_t     rd_data;
  count_t     cnt_old;
  count_t     cnt_new;
  hist_wr_t   hist_wr;
  hist_wr_t   cnt_wr;

  // ---------------------------------------------------------------------------
  // configuration port, zero wait state
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrTolerance);
  assign prdata = (paddr == AddrTolerance) ? {24'd0, tol_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 8'd64;
    end else if (cfg_wr) begin
      tol_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // input handshake: a new request only while the sequencer runs and the
  // output register is free or being emptied this cycle
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == StRun) && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // histogram memory access
  // ---------------------------------------------------------------------------
  assign pix_addr  = bin_index(bucket_of(pixel_red_i), bucket_of(pixel_green_i),
                               bucket_of(pixel_blue_i));
  assign scan_addr = bin_index(scan_r_q, scan_g_q, scan_b_q);
  assign rd_addr   = (state_q == StScan) ? scan_addr : pix_addr;

  // read-modify-write of a counted bin, saturating
  assign cnt_old = (fwd_en_q && (fwd_addr_q == s1_addr_q)) ? fwd_data_q : rd_data;
  assign cnt_new = (cnt_old == CountMax) ? cnt_old : cnt_old + 1'b1;

  always_comb begin
    cnt_wr.en   = s1_valid_q;
    cnt_wr.addr = s1_addr_q;
    cnt_wr.data = cnt_new;
    if (state_q == StScan) begin
      // each bin is cleared at the edge it is read
      hist_wr.en   = 1'b1;
      hist_wr.addr = scan_addr;
      hist_wr.data = '0;
    end else begin
      hist_wr = cnt_wr;
    end
  end

  dcck_hist u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (hist_wr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_en_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_accept && (operation_i == OpCount);
      fwd_en_q   <= cnt_wr.en;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= pix_addr;
    fwd_addr_q <= cnt_wr.addr;
    fwd_data_q <= cnt_wr.data;
  end

  // ---------------------------------------------------------------------------
  // scan counters and argmax compare
  // ---------------------------------------------------------------------------
  assign scan_last = (scan_r_q == BucketLast) && (scan_g_q == BucketLast) &&
                     (scan_b_q == BucketLast);

  always_comb begin
    scan_r_d = scan_r_q;
    scan_g_d = scan_g_q;
    scan_b_d = scan_b_q;
    if (state_q == StScan) begin
      if (scan_b_q == BucketLast) begin
        scan_b_d = '0;
        if (scan_g_q == BucketLast) begin
          scan_g_d = '0;
          scan_r_d = (scan_r_q == BucketLast) ? '0 : scan_r_q + 1'b1;
        end else begin
          scan_g_d = scan_g_q + 1'b1;
        end
      end else begin
        scan_b_d = scan_b_q + 1'b1;
      end
    end
  end

  // bin 0 seeds the candidate, later bins win only on a strict maximum
  assign cmp_take = ((cmp_r_q == '0) && (cmp_g_q == '0) && (cmp_b_q == '0)) ||
                    (rd_data > top_q);
  assign cmp_last = cmp_valid_q && (cmp_r_q == BucketLast) && (cmp_g_q == BucketLast) &&
                    (cmp_b_q == BucketLast);

  always_comb begin
    top_d    = top_q;
    best_r_d = best_r_q;
    best_g_d = best_g_q;
    best_b_d = best_b_q;
    if (cmp_valid_q && cmp_take) begin
      top_d    = rd_data;
      best_r_d = cmp_r_q;
      best_g_d = cmp_g_q;
      best_b_d = cmp_b_q;
    end
  end

  always_comb begin
    key_r_d = key_r_q;
    key_g_d = key_g_q;
    key_b_d = key_b_q;
    if (cmp_last) begin
      key_r_d = key_of(best_r_d);
      key_g_d = key_of(best_g_d);
      key_b_d = key_of(best_b_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_r_q    <= '0;
      scan_g_q    <= '0;
      scan_b_q    <= '0;
      cmp_valid_q <= 1'b0;
      key_r_q     <= KeyReset;
      key_g_q     <= KeyReset;
      key_b_q     <= KeyReset;
    end else begin
      scan_r_q    <= scan_r_d;
      scan_g_q    <= scan_g_d;
      scan_b_q    <= scan_b_d;
      cmp_valid_q <= (state_q == StScan);
      key_r_q     <= key_r_d;
      key_g_q     <= key_g_d;
      key_b_q     <= key_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_r_q  <= scan_r_q;
    cmp_g_q  <= scan_g_q;
    cmp_b_q  <= scan_b_q;
    top_q    <= top_d;
    best_r_q <= best_r_d;
    best_g_q <= best_g_d;
    best_b_q <= best_b_d;
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StRun: begin
        if (in_accept && (operation_i == OpCount) && frame_end_i) begin
          state_d = StWait;
        end
      end
      StWait: begin
        state_d = StScan;
      end
      StScan: begin
        if (scan_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StRun;
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // replace pass: compare against the key and register the composited pixel
  // ---------------------------------------------------------------------------
  assign hit = near_key(pixel_red_i, key_r_q, tol_q) &&
               near_key(pixel_green_i, key_g_q, tol_q) &&
               near_key(pixel_blue_i, key_b_q, tol_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && (operation_i == OpReplace)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && (operation_i == OpReplace)) begin
      out_r_q    <= hit ? bg_red_i : pixel_red_i;
      out_g_q    <= hit ? bg_green_i : pixel_green_i;
      out_b_q    <= hit ? bg_blue_i : pixel_blue_i;
      replaced_q <= hit;
      okey_r_q   <= key_r_q;
      okey_g_q   <= key_g_q;
      okey_b_q   <= key_b_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_r_q;
  assign out_green_o     = out_g_q;
  assign out_blue_o      = out_b_q;
  assign replaced_o      = replaced_q;
  assign key_red_now_o   = okey_r_q;
  assign key_green_now_o = okey_g_q;
  assign key_blue_now_o  = okey_b_q;

endmodule
`default_nettype wire

[sv/dcck_hist.sv]
// histogram bin memory with per-bin valid bits, one read and one write port
`timescale 1ns / 1ps
`default_nettype none
module dcck_hist import dcck_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  bin_addr_t rd_addr_i,
  input  hist_wr_t  wr_i,
  output count_t    rd_data_o
);

  count_t               bin_mem [BinTotal];
  count_t               rd_mem_q;
  logic                 rd_valid_q;
  logic [BinTotal-1:0]  valid_q;

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      bin_mem[wr_i.addr] <= wr_i.data;
    end
    rd_mem_q <= bin_mem[rd_addr_i];
  end

  // never-written bins read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_addr_i];
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_mem_q : '0;

endmodule
`default_nettype wire

[sv/dcck_checker.sv]
// port-level checker for the chroma key block and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "dominant_color_chroma_key_defines.svh"
module dcck_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       operation_i,
  input wire       frame_end_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] out_red_o,
  input wire       pready
);

  // a stalled result stays
  `DCCK_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_red_o)), "result dropped or changed while stalled")

  // a frame-end count request starts the bin scan and stalls input
  `DCCK_ASSERT(a_fe_stall, (in_valid_i && in_ready_o && !operation_i && frame_end_i) |=> !in_ready_o, "input taken during bin scan")

  // the stall lasts into the bin scan: input is still held off there
  `DCCK_ASSERT(a_fe_stall2, (in_valid_i && in_ready_o && !operation_i && frame_end_i) |=> ##1 !in_ready_o, "bin scan ended too early")

  // zero wait state configuration port
  `DCCK_ASSERT_NEVER(a_pready, !pready, "configuration port inserted a wait state")

endmodule

bind dominant_color_chroma_key dcck_checker u_dcck_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .operation_i (operation_i),
  .frame_end_i (frame_end_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_red_o   (out_red_o),
  .pready      (pready)
);
`default_nettype wire
